/* src/psl_pkg.sv */
// Package for the priority-sorted process lists block.
// Field widths, result and action codes, and the command struct that
// drives the list cells. No dependencies.
`default_nettype none

package psl_pkg;

	// Fixed field widths of the stream items
	localparam int PID_FW     = 4;
	localparam int LIST_FW    = 2;
	localparam int PRIO_FW    = 3;
	localparam int OUTCOME_FW = 2;
	localparam int COUNT_FW   = 5;

	// Widest id and priority that the parameter ranges allow
	localparam int CMD_PID_W  = 8;
	localparam int CMD_PRIO_W = 6;

	// Default sizes
	localparam int MAX_PROCESSES_D   = 16;
	localparam int NUM_LISTS_D       = 3;
	localparam int PRIORITY_LEVELS_D = 6;

	// Action codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// Result outcome codes
	typedef enum logic [OUTCOME_FW-1:0] {
		OUT_DONE      = 2'd0,
		OUT_NOT_FOUND = 2'd1,
		OUT_REJECTED  = 2'd2
	} outcome_t;

	// Command broadcast to every cell of one list
	typedef struct packed {
		logic                  ins;
		logic                  rem;
		logic [CMD_PID_W-1:0]  pid;
		logic [CMD_PRIO_W-1:0] prio;
	} cmd_t;

endpackage

`default_nettype wire

/* src/psl_cell.sv */
// One slot of a sorted list: holds an id and its priority and trades
// them with its neighbors on insert (shift toward the tail) and remove.
// Depends on psl_pkg.
`default_nettype none

module psl_cell #(
	parameter int IdW   = 4,
	parameter int PrioW = 3
) (
	input  wire logic             clk,
	input  wire psl_pkg::cmd_t    cmd,
	input  wire logic             valid,
	input  wire logic             left_lt,
	input  wire logic             left_hit,
	input  wire logic [IdW-1:0]   left_id,
	input  wire logic [PrioW-1:0] left_prio,
	input  wire logic [IdW-1:0]   right_id,
	input  wire logic [PrioW-1:0] right_prio,
	output logic                  lt,
	output logic                  hit,
	output logic [IdW-1:0]        id_q,
	output logic [PrioW-1:0]      prio_q,
	output logic [IdW-1:0]        id_d
);

	logic [IdW-1:0]   cmd_id;
	logic [PrioW-1:0] cmd_prio;
	logic [PrioW-1:0] prio_d;

	assign cmd_id   = cmd.pid[IdW-1:0];
	assign cmd_prio = cmd.prio[PrioW-1:0];

	// Entry sorts ahead of the new one; match chain for remove
	assign lt  = valid && (prio_q < cmd_prio);
	assign hit = left_hit || (valid && (id_q == cmd_id));

	// First non-lower slot takes the new entry, later slots take the left one
	always_comb begin
		id_d   = id_q;
		prio_d = prio_q;
		if (cmd.ins) begin
			if (!lt) begin
				if (left_lt) begin
					id_d   = cmd_id;
					prio_d = cmd_prio;
				end else begin
					id_d   = left_id;
					prio_d = left_prio;
				end
			end
		end else if (cmd.rem && hit) begin
			id_d   = right_id;
			prio_d = right_prio;
		end
	end

	always_ff @(posedge clk) begin
		id_q   <= id_d;
		prio_q <= prio_d;
	end

endmodule

`default_nettype wire

/* src/psl_list.sv */
// One sorted list: a chain of psl_cell slots plus the entry count.
// Reports next head, current and next count, whether a remove found its id, and full.
// Depends on psl_pkg and psl_cell.
`default_nettype none

module psl_list #(
	parameter int MaxProc = 16,
	parameter int IdW     = 4,
	parameter int PrioW   = 3,
	parameter int CntW    = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire psl_pkg::cmd_t cmd,
	output logic [CntW-1:0]    count_q,
	output logic [CntW-1:0]    count_nxt,
	output logic [IdW-1:0]     head_nxt,
	output logic               found,
	output logic               full
);

	logic             lt    [MaxProc];
	logic             hit   [MaxProc];
	logic [IdW-1:0]   ids   [MaxProc];
	logic [PrioW-1:0] prios [MaxProc];
	logic [IdW-1:0]   ids_d [MaxProc];

	// Row of slots, each linked to both neighbors
	for (genvar i = 0; i < MaxProc; i++) begin : g_cell
		logic             l_lt;
		logic             l_hit;
		logic [IdW-1:0]   l_id;
		logic [PrioW-1:0] l_prio;
		logic [IdW-1:0]   r_id;
		logic [PrioW-1:0] r_prio;

		if (i == 0) begin : g_first
			assign l_lt   = 1'b1;
			assign l_hit  = 1'b0;
			assign l_id   = ids[i];
			assign l_prio = prios[i];
		end else begin : g_mid
			assign l_lt   = lt[i-1];
			assign l_hit  = hit[i-1];
			assign l_id   = ids[i-1];
			assign l_prio = prios[i-1];
		end

		if (i == MaxProc - 1) begin : g_last
			assign r_id   = ids[i];
			assign r_prio = prios[i];
		end else begin : g_inner
			assign r_id   = ids[i+1];
			assign r_prio = prios[i+1];
		end

		psl_cell #(
			.IdW   (IdW),
			.PrioW (PrioW)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.valid      (count_q > CntW'(i)),
			.left_lt    (l_lt),
			.left_hit   (l_hit),
			.left_id    (l_id),
			.left_prio  (l_prio),
			.right_id   (r_id),
			.right_prio (r_prio),
			.lt         (lt[i]),
			.hit        (hit[i]),
			.id_q       (ids[i]),
			.prio_q     (prios[i]),
			.id_d       (ids_d[i])
		);
	end

	assign found = hit[MaxProc-1];
	assign full  = (count_q == CntW'(MaxProc));

	// Count after this cycle's operation
	always_comb begin
		count_nxt = count_q;
		if (cmd.ins) begin
			count_nxt = count_q + CntW'(1);
		end else if (cmd.rem && found) begin
			count_nxt = count_q - CntW'(1);
		end
	end

	assign head_nxt = (count_nxt != '0) ? ids_d[0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

endmodule

`default_nettype wire

/* src/priority_sorted_process_lists_unit.sv */
// Priority-sorted process lists: top level with the stream ports,
// process table and result register. Depends on psl_pkg and psl_list.
//
// Usage:
//  - Slave stream s_*: one command per transfer. s_tuser is the action
//    (insert or remove); s_tdata carries process id, target list and
//    priority. Target list and priority matter only for insert.
//  - Master stream m_*: one result per command, in command order: outcome,
//    affected list, head valid, head process id and the list's entry count
//    after the command.
//  - Timing: the result is registered and appears in the cycle after the command transfer.
//  - Throughput: one command per cycle while s_tready is high. Insert and remove
//    are each settled by the slot chain of the affected list; a remove ripples its
//    match through all MAX_PROCESSES slots of that list.
//  - Stall: s_tready is high while the result register is empty or is
//    being taken in the same cycle, so a stalled receiver holds at most one
//    result and then holds off the sender.
//  - Reset (arst_n low): all lists empty, no process listed, every recorded
//    status back to list 0. No clearing pass; commands are taken at once.
`default_nettype none

module priority_sorted_process_lists_unit #(
	parameter int MAX_PROCESSES   = psl_pkg::MAX_PROCESSES_D,
	parameter int NUM_LISTS       = psl_pkg::NUM_LISTS_D,
	parameter int PRIORITY_LEVELS = psl_pkg::PRIORITY_LEVELS_D
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // process_id[3:0], target_list[5:4], priority_req[8:6]
	input  wire logic        s_tuser,  // action[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata   // outcome[1:0], affected_list[3:2], head_valid[4],
	                                   // head_process[8:5], list_count[13:9]
);

	localparam int IdW   = $clog2(MAX_PROCESSES);
	localparam int ListW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int PrioW = $clog2(PRIORITY_LEVELS);
	localparam int CntW  = $clog2(MAX_PROCESSES + 1);
	localparam int SumW  = $clog2(NUM_LISTS * MAX_PROCESSES + 1);

	logic                           s_acc;
	logic                           is_ins;
	logic [psl_pkg::PID_FW-1:0]     pid_in;
	logic [psl_pkg::LIST_FW-1:0]    tgt_in;
	logic [psl_pkg::PRIO_FW-1:0]    prio_in;
	logic [IdW-1:0]                 pid_s;
	logic [ListW-1:0]               tgt_s;
	logic [PrioW-1:0]               prio_s;
	logic [ListW-1:0]               stat_raw;
	logic [ListW-1:0]               rem_list;
	logic [ListW-1:0]               sel_list;
	logic                           listed;
	logic                           ins_ok;
	logic                           rem_go;
	logic                           rem_ok;
	psl_pkg::outcome_t              outcome;
	logic [psl_pkg::COUNT_FW-1:0]   res_count;
	logic [psl_pkg::PID_FW-1:0]     res_head;
	logic [SumW-1:0]                total;

	logic [MAX_PROCESSES-1:0]       listed_q;
	logic [ListW-1:0]               status_q [MAX_PROCESSES];
	logic                           m_tvalid_q;
	logic [15:0]                    m_tdata_q;

	psl_pkg::cmd_t                  cmd      [NUM_LISTS];
	logic [CntW-1:0]                cnt_q    [NUM_LISTS];
	logic [CntW-1:0]                cnt_nxt  [NUM_LISTS];
	logic [IdW-1:0]                 head_nxt [NUM_LISTS];
	logic                           found    [NUM_LISTS];
	logic                           full     [NUM_LISTS];

	assign s_tready = !m_tvalid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Field unpacking and saturation
	assign is_ins  = (s_tuser == psl_pkg::ACT_INSERT);
	assign pid_in  = s_tdata[3:0];
	assign tgt_in  = s_tdata[5:4];
	assign prio_in = s_tdata[8:6];

	always_comb begin
		pid_s  = (int'(pid_in) >= MAX_PROCESSES) ? IdW'(MAX_PROCESSES - 1) : IdW'(pid_in);
		tgt_s  = (int'(tgt_in) >= NUM_LISTS) ? ListW'(NUM_LISTS - 1) : ListW'(tgt_in);
		prio_s = (int'(prio_in) >= PRIORITY_LEVELS) ? PrioW'(PRIORITY_LEVELS - 1)
		                                            : PrioW'(prio_in);
	end

	// Process table lookup and list selection
	assign stat_raw = status_q[pid_s];
	assign rem_list = (int'(stat_raw) >= NUM_LISTS) ? ListW'(NUM_LISTS - 1) : stat_raw;
	assign sel_list = is_ins ? tgt_s : rem_list;
	assign listed   = listed_q[pid_s];

	assign ins_ok = s_acc && is_ins && !listed && !full[sel_list];
	assign rem_go = s_acc && !is_ins && listed;
	assign rem_ok = rem_go && found[sel_list];

	// One slot chain per list
	for (genvar l = 0; l < NUM_LISTS; l++) begin : g_list
		assign cmd[l].ins  = ins_ok && (sel_list == ListW'(l));
		assign cmd[l].rem  = rem_go && (sel_list == ListW'(l));
		assign cmd[l].pid  = psl_pkg::CMD_PID_W'(pid_s);
		assign cmd[l].prio = psl_pkg::CMD_PRIO_W'(prio_s);

		psl_list #(
			.MaxProc (MAX_PROCESSES),
			.IdW     (IdW),
			.PrioW   (PrioW),
			.CntW    (CntW)
		) u_list (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd[l]),
			.count_q   (cnt_q[l]),
			.count_nxt (cnt_nxt[l]),
			.head_nxt  (head_nxt[l]),
			.found     (found[l]),
			.full      (full[l])
		);
	end

	// Result fields
	always_comb begin
		if (is_ins) begin
			outcome = ins_ok ? psl_pkg::OUT_DONE : psl_pkg::OUT_REJECTED;
		end else begin
			outcome = rem_ok ? psl_pkg::OUT_DONE : psl_pkg::OUT_NOT_FOUND;
		end
	end

	assign res_count = psl_pkg::COUNT_FW'(cnt_nxt[sel_list]);
	assign res_head  = psl_pkg::PID_FW'(head_nxt[sel_list]);

	// Process table and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listed_q   <= '0;
			status_q   <= '{default: '0};
			m_tvalid_q <= 1'b0;
		end else begin
			if (ins_ok) begin
				listed_q[pid_s] <= 1'b1;
				status_q[pid_s] <= tgt_s;
			end else if (rem_ok) begin
				listed_q[pid_s] <= 1'b0;
			end
			if (s_acc) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			m_tdata_q <= {2'b00, res_count, res_head, (res_count != '0),
			              psl_pkg::LIST_FW'(sel_list), outcome};
		end
	end

	// Total entries across lists, for checking
	always_comb begin
		total = '0;
		for (int l = 0; l < NUM_LISTS; l++) begin
			total = total + SumW'(cnt_q[l]);
		end
	end

	// The number of listed processes equals the total entries across all lists
	a_count_matches_listed: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(listed_q) == int'(total))
		else $error("list counts disagree with listed processes");

	// An accepted command always yields a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> m_tvalid_q)
		else $error("result missing after command transfer");

	// A completed insert leaves the process listed and its list non-empty
	a_insert_lists: assert property (@(posedge clk) disable iff (!arst_n)
		ins_ok |=> (listed_q[$past(pid_s)] && m_tdata_q[4]))
		else $error("insert did not list the process");

	// A completed remove clears the listed flag
	a_remove_unlists: assert property (@(posedge clk) disable iff (!arst_n)
		rem_ok |=> !listed_q[$past(pid_s)])
		else $error("remove left the process listed");

endmodule

`default_nettype wire
